// ===== src/pgt_pkg.sv =====
package pgt_pkg;

	localparam int GAIN_COUNT_DEF = 3;
	localparam int COUNT_BITS_DEF = 16;

	localparam int SUM_W  = 48;
	localparam int AVG_W  = 31;
	localparam int STEP_W = 32;
	localparam int SCL_W  = 16;
	localparam int IDX_OUT_W = 2;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 31;

	localparam logic signed [STEP_W-1:0] STEP_RESET = 32'sd6554;
	localparam logic [AVG_W-1:0] TOL_RESET  = 31'd655;
	localparam logic [SCL_W-1:0] GROW_POS_RESET = 16'd4506;
	localparam logic [SCL_W-1:0] GROW_NEG_RESET = 16'd4915;
	localparam logic [SCL_W-1:0] SHRINK_RESET   = 16'd3686;
	localparam logic [AVG_W-1:0] AVG_MAX = {AVG_W{1'b1}};

	typedef enum logic [1:0] {
		FUNC_SAMPLE = 2'd0,
		FUNC_TUNE   = 2'd1,
		FUNC_CLEAR  = 2'd2,
		FUNC_NOP    = 2'd3
	} func_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_INITIAL_STEP   = 3'd0,
		CFG_STOP_TOLERANCE = 3'd1,
		CFG_GROW_POSITIVE  = 3'd2,
		CFG_GROW_NEGATIVE  = 3'd3,
		CFG_SHRINK         = 3'd4
	} cfg_idx_t;

	typedef struct packed {
		logic             start;
		logic [STEP_W-1:0] mag;
		logic [SCL_W-1:0]  factor;
		logic              negative;
	} scale_req_t;

endpackage

// ===== src/pid_gain_twiddle_tuner.sv =====
// Sample, clear and no-op requests, and a tune with no samples or after convergence, go from
// acceptance through the done state into the result registers. Any other tune first runs the
// bit-serial divider for the average, then the decide, scale (when rescaled) and fetch states.
// Throughput: one request at a time; the next request is taken once the result is registered.
// Reset (arst_n low, asynchronous) restores all gains' steps, sums and control registers; result data is not reset.
module pid_gain_twiddle_tuner import pgt_pkg::*; #(
	parameter int GAIN_COUNT = GAIN_COUNT_DEF,
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [CFG_IDX_W-1:0]        cfg_index,
	input  logic [CFG_DAT_W-1:0]        cfg_data,
	input  logic                        req_valid,
	output logic                        req_ready,
	input  logic [1:0]                  func,
	input  logic signed [STEP_W-1:0]    error_sample,
	output logic                        res_valid,
	input  logic                        res_ready,
	output logic                        tuned,
	output logic                        undo_valid,
	output logic [IDX_OUT_W-1:0]        undo_index,
	output logic signed [STEP_W-1:0]    undo_amount,
	output logic [IDX_OUT_W-1:0]        adjust_index,
	output logic signed [STEP_W-1:0]    adjust_amount,
	output logic [AVG_W-1:0]            last_average,
	output logic [AVG_W-1:0]            best_average,
	output logic                        converged
);

	localparam int IDX_W = (GAIN_COUNT > 1) ? $clog2(GAIN_COUNT) : 1;

	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_DIV    = 6'b000010,
		ST_DECIDE = 6'b000100,
		ST_SCALE  = 6'b001000,
		ST_FETCH  = 6'b010000,
		ST_DONE   = 6'b100000
	} state_t;

	state_t state_q;

	logic [AVG_W-1:0] tol_q;
	logic [SCL_W-1:0] grow_pos_q;
	logic [SCL_W-1:0] grow_neg_q;
	logic [SCL_W-1:0] shrink_q;

	logic signed [STEP_W-1:0] step_q [GAIN_COUNT];
	logic [IDX_W-1:0]         step_index_q;
	logic signed [STEP_W-1:0] last_delta_q;
	logic [SUM_W-1:0]         sum_q;
	logic [COUNT_BITS-1:0]    count_q;
	logic                     first_q;
	logic [AVG_W-1:0]         best_q;
	logic [AVG_W-1:0]         last_q;
	logic [AVG_W-1:0]         avg_q;
	logic                     adv_q;

	logic                     tuned_q;
	logic                     undo_valid_q;
	logic [IDX_OUT_W-1:0]     undo_index_q;
	logic signed [STEP_W-1:0] undo_amount_q;
	logic [IDX_OUT_W-1:0]     adjust_index_q;
	logic signed [STEP_W-1:0] adjust_amount_q;

	logic                     res_valid_q;
	logic                     res_tuned_q;
	logic                     res_undo_valid_q;
	logic [IDX_OUT_W-1:0]     res_undo_index_q;
	logic signed [STEP_W-1:0] res_undo_amount_q;
	logic [IDX_OUT_W-1:0]     res_adjust_index_q;
	logic signed [STEP_W-1:0] res_adjust_amount_q;
	logic [AVG_W-1:0]         res_last_q;
	logic [AVG_W-1:0]         res_best_q;
	logic                     res_conv_q;

	logic                     accept;
	logic                     conv;
	logic [STEP_W-1:0]        mag_in;
	logic [SUM_W:0]           sum_add;
	logic signed [STEP_W-1:0] cur_step;
	logic [STEP_W-1:0]        cur_mag;
	logic                     cur_pos;
	logic [IDX_W-1:0]         next_index;
	logic                     div_start;
	logic                     div_busy;
	logic                     div_done;
	logic [AVG_W-1:0]         div_quo;
	scale_req_t               scl_req;
	logic signed [STEP_W-1:0] scl_result;
	logic                     out_free;

	assign req_ready = (state_q == ST_IDLE);
	assign accept    = req_valid && req_ready;
	assign conv      = best_q < tol_q;
	assign out_free  = !res_valid_q || res_ready;

	always_comb begin
		mag_in     = error_sample[STEP_W-1] ? (32'd0 - error_sample) : error_sample;
		sum_add    = {1'b0, sum_q} + (SUM_W+1)'(mag_in);
		cur_step   = step_q[step_index_q];
		cur_pos    = !cur_step[STEP_W-1] && (cur_step != '0);
		cur_mag    = cur_pos ? cur_step : (32'd0 - cur_step);
		next_index = (step_index_q == IDX_W'(GAIN_COUNT - 1)) ? '0 : step_index_q + 1'b1;
		div_start  = accept && (func_t'(func) == FUNC_TUNE) && !conv && (count_q != '0);

		scl_req.start    = (state_q == ST_DECIDE) && !first_q &&
			((avg_q < best_q) || !cur_pos);
		scl_req.mag      = cur_mag;
		scl_req.factor   = (avg_q < best_q) ? (cur_pos ? grow_pos_q : grow_neg_q) : shrink_q;
		scl_req.negative = (avg_q < best_q) && !cur_pos;
	end

	pgt_divider #(
		.COUNT_BITS(COUNT_BITS)
	) u_divider (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (sum_q),
		.divisor  (count_q),
		.busy     (div_busy),
		.done     (div_done),
		.quotient (div_quo)
	);

	pgt_scaler u_scaler (
		.clk    (clk),
		.req    (scl_req),
		.result (scl_result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q      <= TOL_RESET;
			grow_pos_q <= GROW_POS_RESET;
			grow_neg_q <= GROW_NEG_RESET;
			shrink_q   <= SHRINK_RESET;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_STOP_TOLERANCE: tol_q      <= cfg_data;
				CFG_GROW_POSITIVE:  grow_pos_q <= cfg_data[SCL_W-1:0];
				CFG_GROW_NEGATIVE:  grow_neg_q <= cfg_data[SCL_W-1:0];
				CFG_SHRINK:         shrink_q   <= cfg_data[SCL_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_IDLE;
			for (int i = 0; i < GAIN_COUNT; i++) step_q[i] <= STEP_RESET;
			step_index_q    <= '0;
			last_delta_q    <= '0;
			sum_q           <= '0;
			count_q         <= '0;
			first_q         <= 1'b1;
			best_q          <= AVG_MAX;
			last_q          <= '0;
			avg_q           <= '0;
			adv_q           <= 1'b0;
			tuned_q         <= 1'b0;
			undo_valid_q    <= 1'b0;
			undo_index_q    <= '0;
			undo_amount_q   <= '0;
			adjust_index_q  <= '0;
			adjust_amount_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						tuned_q         <= 1'b0;
						undo_valid_q    <= 1'b0;
						undo_index_q    <= '0;
						undo_amount_q   <= '0;
						adjust_index_q  <= '0;
						adjust_amount_q <= '0;
						state_q         <= div_start ? ST_DIV : ST_DONE;
						case (func_t'(func))
							FUNC_SAMPLE: begin
								if (!conv) begin
									sum_q <= sum_add[SUM_W] ? {SUM_W{1'b1}} : sum_add[SUM_W-1:0];
									if (count_q != {COUNT_BITS{1'b1}}) count_q <= count_q + 1'b1;
								end
							end
							FUNC_CLEAR: begin
								step_index_q <= '0;
								last_delta_q <= '0;
								sum_q        <= '0;
								count_q      <= '0;
							end
							default: ;
						endcase
					end
				end
				ST_DIV: begin
					if (div_done) begin
						avg_q   <= div_quo;
						state_q <= ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					adv_q <= 1'b0;
					if (first_q) begin
						best_q  <= avg_q;
						first_q <= 1'b0;
						state_q <= ST_FETCH;
					end else if (avg_q < best_q) begin
						best_q  <= avg_q;
						adv_q   <= 1'b1;
						state_q <= ST_SCALE;
					end else begin
						undo_valid_q  <= 1'b1;
						undo_index_q  <= IDX_OUT_W'(step_index_q);
						undo_amount_q <= last_delta_q;
						if (cur_pos) begin
							step_q[step_index_q] <= 32'sd0 - cur_step;
							state_q              <= ST_FETCH;
						end else begin
							adv_q   <= 1'b1;
							state_q <= ST_SCALE;
						end
					end
				end
				ST_SCALE: begin
					step_q[step_index_q] <= scl_result;
					if (adv_q) step_index_q <= next_index;
					state_q <= ST_FETCH;
				end
				ST_FETCH: begin
					last_delta_q    <= cur_step;
					adjust_index_q  <= IDX_OUT_W'(step_index_q);
					adjust_amount_q <= cur_step;
					sum_q           <= '0;
					count_q         <= '0;
					last_q          <= avg_q;
					tuned_q         <= 1'b1;
					state_q         <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			res_tuned_q         <= tuned_q;
			res_undo_valid_q    <= undo_valid_q;
			res_undo_index_q    <= undo_index_q;
			res_undo_amount_q   <= undo_amount_q;
			res_adjust_index_q  <= adjust_index_q;
			res_adjust_amount_q <= adjust_amount_q;
			res_last_q          <= last_q;
			res_best_q          <= best_q;
			res_conv_q          <= conv;
		end
	end

	assign res_valid     = res_valid_q;
	assign tuned         = res_tuned_q;
	assign undo_valid    = res_undo_valid_q;
	assign undo_index    = res_undo_index_q;
	assign undo_amount   = res_undo_amount_q;
	assign adjust_index  = res_adjust_index_q;
	assign adjust_amount = res_adjust_amount_q;
	assign last_average  = res_last_q;
	assign best_average  = res_best_q;
	assign converged     = res_conv_q;

	a_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		step_index_q <= IDX_W'(GAIN_COUNT - 1))
		else $error("step index beyond the last gain");

	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !div_busy)
		else $error("divider busy while waiting for a request");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !req_ready)
		else $error("request taken while the previous one is in progress");

	a_untuned_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !tuned) |-> (!undo_valid && adjust_amount == '0 && undo_amount == '0))
		else $error("deltas reported without a tune step");

endmodule

// ===== src/pgt_divider.sv =====
module pgt_divider import pgt_pkg::*; #(
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [SUM_W-1:0]      dividend,
	input  logic [COUNT_BITS-1:0] divisor,
	output logic                  busy,
	output logic                  done,
	output logic [AVG_W-1:0]      quotient
);

	localparam int CNT_W = $clog2(SUM_W);

	logic                  busy_q;
	logic                  done_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [COUNT_BITS-1:0] rem_q;
	logic [COUNT_BITS-1:0] div_q;
	logic [SUM_W-1:0]      quo_q;
	logic [COUNT_BITS:0]   shifted;
	logic                  ge;
	logic [COUNT_BITS:0]   diff;

	always_comb begin
		shifted = {rem_q, quo_q[SUM_W-1]};
		ge      = shifted >= {1'b0, div_q};
		diff    = shifted - {1'b0, div_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == CNT_W'(SUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			div_q <= divisor;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= ge ? diff[COUNT_BITS-1:0] : shifted[COUNT_BITS-1:0];
			quo_q <= {quo_q[SUM_W-2:0], ge};
		end
	end

	assign busy     = busy_q;
	assign done     = done_q;
	assign quotient = (quo_q[SUM_W-1:AVG_W] != '0) ? AVG_MAX : quo_q[AVG_W-1:0];

endmodule

// ===== src/pgt_scaler.sv =====
module pgt_scaler import pgt_pkg::*; (
	input  logic                     clk,
	input  scale_req_t               req,
	output logic signed [STEP_W-1:0] result
);

	localparam int PROD_W = STEP_W + SCL_W;
	localparam int P_W    = PROD_W - 12;

	logic [PROD_W-1:0] prod_q;
	logic              neg_q;
	logic [PROD_W-1:0] rounded;
	logic [P_W-1:0]    p;
	logic [STEP_W-1:0] pc;

	always_ff @(posedge clk) begin
		if (req.start) begin
			prod_q <= PROD_W'(req.mag) * PROD_W'(req.factor);
			neg_q  <= req.negative;
		end
	end

	always_comb begin
		rounded = prod_q + PROD_W'(2048);
		p       = rounded[PROD_W-1:12];
		if (neg_q) begin
			pc     = (p > P_W'(33'h080000000)) ? 32'h80000000 : p[STEP_W-1:0];
			result = $signed(32'd0 - pc);
		end else begin
			pc     = (p > P_W'(32'h7FFFFFFF)) ? 32'h7FFFFFFF : p[STEP_W-1:0];
			result = $signed(pc);
		end
	end

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
	import pgt_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 6_000_000;
	localparam int unsigned PRINT_CAP = 200;
	localparam longint unsigned SUM_CAP = 64'hFFFF_FFFF_FFFF;
	localparam int unsigned CNT_CAP = (1 << COUNT_BITS_DEF) - 1;
	localparam int unsigned SAT_SAMPLES = 40;
	localparam int unsigned PHASE_ITEMS = 115;
	localparam logic [31:0] MOST_NEGATIVE = 32'h8000_0000;

	typedef struct packed {
		logic                 tuned;
		logic                 undo_valid;
		logic [IDX_OUT_W-1:0] undo_index;
		logic [STEP_W-1:0]    undo_amount;
		logic [IDX_OUT_W-1:0] adjust_index;
		logic [STEP_W-1:0]    adjust_amount;
		logic [AVG_W-1:0]     last_average;
		logic [AVG_W-1:0]     best_average;
		logic                 converged;
	} tuner_out_t;

	logic                     clk = 1'b0;
	logic                     arst_n;
	logic                     cfg_we;
	logic [CFG_IDX_W-1:0]     cfg_index;
	logic [CFG_DAT_W-1:0]     cfg_data;
	logic                     req_valid;
	logic                     req_ready;
	logic [1:0]               func;
	logic signed [STEP_W-1:0] error_sample;
	logic                     res_valid;
	logic                     res_ready;
	logic                     tuned;
	logic                     undo_valid;
	logic [IDX_OUT_W-1:0]     undo_index;
	logic signed [STEP_W-1:0] undo_amount;
	logic [IDX_OUT_W-1:0]     adjust_index;
	logic signed [STEP_W-1:0] adjust_amount;
	logic [AVG_W-1:0]         last_average;
	logic [AVG_W-1:0]         best_average;
	logic                     converged;

	bit          calm;
	int unsigned cycle_cnt;
	int unsigned items_sent;
	int unsigned mismatch_cnt;
	tuner_out_t  tuner_due[$];
	tuner_out_t  due;

	logic [AVG_W-1:0] cfg_tol;
	logic [SCL_W-1:0] cfg_grow_pos;
	logic [SCL_W-1:0] cfg_grow_neg;
	logic [SCL_W-1:0] cfg_shrink;
	longint           gain_step[GAIN_COUNT_DEF];
	int unsigned      gain_sel;
	longint           prev_delta;
	longint unsigned  abs_sum;
	int unsigned      abs_cnt;
	bit               untuned;
	logic [AVG_W-1:0] best_avg;
	logic [AVG_W-1:0] last_avg;

	pid_gain_twiddle_tuner u_top (.*);

	always #10 clk = ~clk;

	always @(negedge clk)
		res_ready <= calm || ($urandom_range(99) >= 15);

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	task automatic report_mismatch(input string field, input logic [31:0] got, want);
		if (got !== want) begin
			if (mismatch_cnt < PRINT_CAP)
				$display("%0t: %s is %h, expected %h", $time, field, got, want);
			mismatch_cnt++;
		end
	endtask

	always @(posedge clk) begin
		if (res_valid && res_ready) begin
			if (tuner_due.size() == 0) begin
				report_mismatch("result with no request pending", 32'd1, 32'd0);
			end else begin
				due = tuner_due.pop_front();
				report_mismatch("tuned", 32'(tuned), 32'(due.tuned));
				report_mismatch("undo_valid", 32'(undo_valid), 32'(due.undo_valid));
				report_mismatch("undo_index", 32'(undo_index), 32'(due.undo_index));
				report_mismatch("undo_amount", undo_amount, due.undo_amount);
				report_mismatch("adjust_index", 32'(adjust_index), 32'(due.adjust_index));
				report_mismatch("adjust_amount", adjust_amount, due.adjust_amount);
				report_mismatch("last_average", 32'(last_average), 32'(due.last_average));
				report_mismatch("best_average", 32'(best_average), 32'(due.best_average));
				report_mismatch("converged", 32'(converged), 32'(due.converged));
			end
		end
	end

	// Magnitude times a Q4.12 factor, rounded half away from zero, signed and saturated.
	function automatic longint scaled_step(input longint unsigned mag,
			input logic [SCL_W-1:0] factor, input bit neg);
		longint unsigned p;
		p = (mag * 64'(factor) + 64'd2048) >> 12;
		if (neg) begin
			if (p > 64'h8000_0000)
				p = 64'h8000_0000;
			return -longint'(p);
		end
		if (p > 64'h7FFF_FFFF)
			p = 64'h7FFF_FFFF;
		return longint'(p);
	endfunction

	function automatic int unsigned next_gain(input int unsigned k);
		return (k + 1 >= GAIN_COUNT_DEF) ? 0 : k + 1;
	endfunction

	task automatic predict_tuner(input func_t op, input logic [31:0] smp);
		tuner_out_t      r;
		longint unsigned mag;
		longint unsigned avg;
		longint          s;
		int unsigned     k;
		r = '0;
		case (op)
		FUNC_SAMPLE: begin
			if (!(best_avg < cfg_tol)) begin
				mag = smp[31] ? 64'h1_0000_0000 - 64'(smp) : 64'(smp);
				abs_sum = abs_sum + mag;
				if (abs_sum > SUM_CAP)
					abs_sum = SUM_CAP;
				if (abs_cnt < CNT_CAP)
					abs_cnt++;
			end
		end
		FUNC_TUNE: begin
			if (!(best_avg < cfg_tol) && abs_cnt != 0) begin
				avg = abs_sum / 64'(abs_cnt);
				if (avg > 64'(AVG_MAX))
					avg = 64'(AVG_MAX);
				k = gain_sel;
				s = gain_step[k];
				if (untuned) begin
					best_avg = avg[AVG_W-1:0];
					untuned = 1'b0;
				end else if (avg < 64'(best_avg)) begin
					best_avg = avg[AVG_W-1:0];
					gain_step[k] = (s > 0) ? scaled_step(s, cfg_grow_pos, 1'b0)
						: scaled_step(-s, cfg_grow_neg, 1'b1);
					gain_sel = next_gain(k);
				end else begin
					r.undo_valid = 1'b1;
					r.undo_index = IDX_OUT_W'(k);
					r.undo_amount = prev_delta[31:0];
					if (s > 0) begin
						gain_step[k] = -s;
					end else begin
						gain_step[k] = scaled_step(-s, cfg_shrink, 1'b0);
						gain_sel = next_gain(k);
					end
				end
				prev_delta = gain_step[gain_sel];
				r.adjust_index = IDX_OUT_W'(gain_sel);
				r.adjust_amount = prev_delta[31:0];
				abs_sum = 0;
				abs_cnt = 0;
				last_avg = avg[AVG_W-1:0];
				r.tuned = 1'b1;
			end
		end
		FUNC_CLEAR: begin
			gain_sel = 0;
			prev_delta = 0;
			abs_sum = 0;
			abs_cnt = 0;
		end
		default: begin
		end
		endcase
		r.last_average = last_avg;
		r.best_average = best_avg;
		r.converged = best_avg < cfg_tol;
		tuner_due.push_back(r);
	endtask

	task automatic send_req(input func_t op, input logic [31:0] smp);
		@(negedge clk);
		while (!calm && $urandom_range(99) < 15) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req_valid <= 1'b1;
		func <= op;
		error_sample <= smp;
		@(posedge clk);
		while (!req_ready)
			@(posedge clk);
		predict_tuner(op, smp);
		items_sent++;
	endtask

	task automatic drain_results();
		@(negedge clk);
		req_valid <= 1'b0;
		while (tuner_due.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
	endtask

	// Initial step writes are ignored; steps always reset to STEP_RESET.
	task automatic set_config(input logic [AVG_W-1:0] step, tol,
			input logic [SCL_W-1:0] gp, gn, sh);
		drain_results();
		write_reg(CFG_INITIAL_STEP, step);
		write_reg(CFG_STOP_TOLERANCE, tol);
		write_reg(CFG_GROW_POSITIVE, {15'($urandom), gp});
		write_reg(CFG_GROW_NEGATIVE, {15'($urandom), gn});
		write_reg(CFG_SHRINK, {15'($urandom), sh});
		write_reg(3'(CFG_SHRINK) + 3'($urandom_range(3, 1)), 31'($urandom));
		@(negedge clk);
		cfg_we <= 1'b0;
		cfg_tol = tol;
		cfg_grow_pos = gp;
		cfg_grow_neg = gn;
		cfg_shrink = sh;
	endtask

	function automatic logic [31:0] with_sign(input logic [31:0] mag);
		return $urandom_range(1) ? -mag : mag;
	endfunction

	// A batch of samples closed by a tune; a lower target tends to beat the best average.
	task automatic tune_round(input bit aim_lower, input int unsigned n);
		logic [31:0] target;
		logic [31:0] mag;
		if (aim_lower && best_avg > 8)
			target = best_avg - 1 - $urandom_range(best_avg / 4);
		else
			target = $urandom >> $urandom_range(31);
		repeat (n) begin
			mag = target - $urandom_range(target / 8);
			send_req(FUNC_SAMPLE, with_sign(mag));
		end
		send_req(FUNC_TUNE, $urandom);
	endtask

	task automatic test_idle_ops();
		send_req(FUNC_NOP, $urandom);
		send_req(FUNC_TUNE, $urandom);
		send_req(FUNC_CLEAR, $urandom);
	endtask

	task automatic test_twiddle_paths();
		send_req(FUNC_SAMPLE, MOST_NEGATIVE);
		send_req(FUNC_TUNE, '0);
		send_req(FUNC_SAMPLE, 32'h7FFF_FFFF);
		send_req(FUNC_SAMPLE, 32'hFFFF_FFFF);
		send_req(FUNC_SAMPLE, 32'h0000_0000);
		send_req(FUNC_TUNE, 32'hFFFF_FFFF);
		send_req(FUNC_SAMPLE, 32'h4000_0000);
		send_req(FUNC_TUNE, '0);
		send_req(FUNC_SAMPLE, 32'hC000_0000);
		send_req(FUNC_TUNE, '0);
		send_req(FUNC_SAMPLE, 32'h1000_0000);
		send_req(FUNC_TUNE, '0);
		send_req(FUNC_SAMPLE, 32'h2000_0000);
		send_req(FUNC_TUNE, '0);
		send_req(FUNC_SAMPLE, 32'hF800_0000);
		send_req(FUNC_TUNE, '0);
		send_req(FUNC_SAMPLE, 32'h0100_0000);
		send_req(FUNC_CLEAR, '0);
		send_req(FUNC_TUNE, '0);
	endtask

	task automatic test_sum_saturation();
		calm = 1'b1;
		repeat (SAT_SAMPLES) send_req(FUNC_SAMPLE, MOST_NEGATIVE);
		send_req(FUNC_TUNE, '0);
		calm = 1'b0;
	endtask

	task automatic test_convergence();
		logic [AVG_W-1:0] tol_at_best;
		tol_at_best = best_avg;
		set_config(31'($urandom), tol_at_best, GROW_POS_RESET, GROW_NEG_RESET, SHRINK_RESET);
		send_req(FUNC_NOP, $urandom);
		send_req(FUNC_SAMPLE, 32'h0000_1000);
		set_config(31'($urandom), AVG_W'(tol_at_best + 1), GROW_POS_RESET, GROW_NEG_RESET,
			SHRINK_RESET);
		send_req(FUNC_SAMPLE, $urandom);
		send_req(FUNC_TUNE, $urandom);
		send_req(FUNC_CLEAR, $urandom);
		send_req(FUNC_SAMPLE, 32'h0000_0001);
		send_req(FUNC_TUNE, '0);
		set_config(31'($urandom), AVG_MAX, GROW_POS_RESET, GROW_NEG_RESET, SHRINK_RESET);
		send_req(FUNC_NOP, '0);
		send_req(FUNC_TUNE, '0);
		set_config(31'($urandom), '0, GROW_POS_RESET, GROW_NEG_RESET, SHRINK_RESET);
		send_req(FUNC_TUNE, $urandom);
	endtask

	task automatic test_random_phases();
		int unsigned phase_end;
		int unsigned pick;
		for (int p = 0; p < 5; p++) begin
			case (p)
			0: begin
				set_config(STEP_RESET[AVG_W-1:0], 31'($urandom_range(600)), GROW_POS_RESET,
					GROW_NEG_RESET, SHRINK_RESET);
			end
			1: begin
				set_config(AVG_MAX, '0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
			end
			2: begin
				set_config('0, '0, 16'($urandom_range(16384, 2048)),
					16'($urandom_range(16384, 2048)), 16'($urandom_range(16384, 2048)));
			end
			3: begin
				set_config(31'($urandom), '0, 16'($urandom_range(16384, 1024)),
					16'($urandom_range(16384, 1024)), 16'($urandom_range(16384, 1024)));
			end
			default: begin
				set_config(31'($urandom), '0, 16'($urandom_range(65535, 2048)),
					16'($urandom_range(65535, 2048)), 16'($urandom_range(65535, 2048)));
			end
			endcase
			calm = (p == 1);
			phase_end = items_sent + PHASE_ITEMS;
			while (items_sent < phase_end) begin
				pick = $urandom_range(99);
				if (pick < 70) begin
					tune_round($urandom_range(1), ($urandom_range(9) == 0)
						? $urandom_range(40, 7) : $urandom_range(6, 1));
				end else if (pick < 85) begin
					send_req(func_t'(2'($urandom_range(3))), $urandom);
				end else if (pick < 95) begin
					repeat ($urandom_range(3, 1)) send_req(FUNC_SAMPLE, $urandom);
					send_req(FUNC_CLEAR, $urandom);
					if ($urandom_range(1))
						send_req(FUNC_TUNE, $urandom);
				end else if (pick < 98) begin
					drain_results();
				end else begin
					send_req(FUNC_NOP, $urandom);
				end
			end
		end
		calm = 1'b0;
	endtask

	// Zero factors pin every step at zero, so this runs last.
	task automatic test_zero_scales();
		set_config(STEP_RESET[AVG_W-1:0], '0, '0, '0, '0);
		repeat (12) tune_round($urandom_range(1), $urandom_range(4, 1));
		repeat (2) send_req(FUNC_SAMPLE, '0);
		send_req(FUNC_TUNE, '0);
		send_req(FUNC_SAMPLE, '0);
		send_req(FUNC_TUNE, '0);
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		req_valid = 1'b0;
		func = FUNC_NOP;
		error_sample = '0;
		calm = 1'b0;
		cfg_tol = TOL_RESET;
		cfg_grow_pos = GROW_POS_RESET;
		cfg_grow_neg = GROW_NEG_RESET;
		cfg_shrink = SHRINK_RESET;
		foreach (gain_step[i])
			gain_step[i] = STEP_RESET;
		gain_sel = 0;
		prev_delta = 0;
		abs_sum = 0;
		abs_cnt = 0;
		untuned = 1'b1;
		best_avg = AVG_MAX;
		last_avg = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_idle_ops();
		test_twiddle_paths();
		test_sum_saturation();
		test_convergence();
		test_random_phases();
		test_zero_scales();
		drain_results();
		repeat (60) @(negedge clk);
		if (mismatch_cnt == 0 && tuner_due.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
